// ===== rtl/assert_macros.svh =====
// Assertion helper macros for the HSV to RGBA8 block.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/hsvrgb_pkg.sv =====
// Shared types, constants and fixed-point helpers for the HSV to RGBA8 block.
// No dependencies; imported by every module of the block.
package hsvrgb_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int CODE_W      = 16;
  localparam int FX_W        = FRAC_BITS + 1;        // holds 0..1.0 inclusive
  localparam int REP         = (FRAC_BITS + CODE_W - 1) / CODE_W;
  localparam int H6_W        = CODE_W + 3;           // hue * 6
  localparam int NUM_SECTORS = 6;

  typedef logic [FX_W-1:0]   fx_t;
  typedef logic [H6_W-1:0]   h6_t;
  typedef logic [CODE_W-1:0] code_t;

  localparam fx_t   FX_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
  localparam h6_t   IN_MAX   = {3'b000, {CODE_W{1'b1}}};
  localparam code_t CODE_MAX = {CODE_W{1'b1}};

  typedef enum logic [2:0] {
    SEC_RY = 3'd0,
    SEC_YG = 3'd1,
    SEC_GC = 3'd2,
    SEC_CB = 3'd3,
    SEC_BM = 3'd4,
    SEC_MR = 3'd5
  } sector_e;

  typedef struct packed {
    code_t hue;
    code_t saturation;
    code_t brightness;
    code_t opacity;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] opacity_byte;
  } color_t;

  // after the sector stage
  typedef struct packed {
    sector_e sector;
    fx_t     frac;
    fx_t     sat;
    fx_t     val;
    fx_t     alpha;
  } sect_t;

  // after the first product stage
  typedef struct packed {
    sector_e sector;
    fx_t     val;
    fx_t     alpha;
    fx_t     p;
    fx_t     fs;   // f * s
    fx_t     gs;   // (1 - f) * s
  } prod_t;

  // after the second product stage
  typedef struct packed {
    sector_e sector;
    fx_t     val;
    fx_t     alpha;
    fx_t     p;
    fx_t     q;
    fx_t     t;
  } mix_t;

  // floor(code * 2^FRAC_BITS / 65535): below full scale the quotient is the
  // code repeated as a binary fraction, so this is wiring only.
  function automatic fx_t to_fix(input code_t code);
    logic [CODE_W*REP-1:0] pat;
    pat = {REP{code}};
    if (code == CODE_MAX) begin
      return FX_ONE;
    end
    return {1'b0, pat[CODE_W*REP-1 -: FRAC_BITS]};
  endfunction

  function automatic fx_t fx_mul(input fx_t a, input fx_t b);
    logic [2*FX_W-1:0] prod;
    prod = (2*FX_W)'(a) * (2*FX_W)'(b);
    return prod[FRAC_BITS +: FX_W];
  endfunction

  // floor(x * 255) as a byte, x * 255 done as x * 256 - x
  function automatic logic [7:0] to_byte(input fx_t x);
    logic [FX_W+7:0] w;
    w = {x, 8'd0} - {8'd0, x};
    return w[FRAC_BITS +: 8];
  endfunction

  function automatic h6_t sector_base(input sector_e sec);
    return h6_t'(sec) * IN_MAX;
  endfunction

endpackage

// ===== rtl/hsv_to_rgba8_convert.sv =====
// HSV plus alpha to RGBA8 pixel converter, top level.
// Depends on hsvrgb_pkg, hsvrgb_sector, hsvrgb_mul, hsvrgb_pack, assert_macros.svh.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+-------------------------------------
//   pixel in | start, busy (always 0)  | pixel: hue, saturation, brightness,
//            |                         |        opacity (16-bit fractions)
//   color out| done (one-cycle strobe) | color: red, green, blue,
//            |                         |        opacity_byte (bytes)
//
// One beat per clock in, one per clock out; each start beat passes through
// the four register stages in order (sector, two multiplier stages,
// routing/byte scaling) before its result shows up with done.
// busy stays low: the pipeline never fills up, since the receiver cannot stall.
// Synchronous reset clears only the stage valid bits; data regs are not reset.
module hsv_to_rgba8_convert (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hsvrgb_pkg::pixel_t  pixel,
  output logic                done,
  output hsvrgb_pkg::color_t  color
);
  import hsvrgb_pkg::*;
  `include "assert_macros.svh"

  logic  sect_valid;
  sect_t sect;
  logic  mix_valid;
  mix_t  mix;

  // pipeline never backs up, so every start beat is taken
  assign busy = 1'b0;

  // stage 1: sector select, in-sector fraction, code to fixed point
  hsvrgb_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start),
    .pixel     (pixel),
    .out_valid (sect_valid),
    .sect      (sect)
  );

  // stages 2 and 3: p/fs/gs, then q/t (each one multiply deep)
  hsvrgb_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sect_valid),
    .sect      (sect),
    .out_valid (mix_valid),
    .mix       (mix)
  );

  // stage 4: channel routing by sector and byte scaling
  hsvrgb_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mix_valid),
    .mix       (mix),
    .out_valid (done),
    .color     (color)
  );

  // every accepted beat comes out as a done strobe
  `ASSERT_HOLDS(a_latency, clk, rst, (start && !busy) |-> ##4 done, "result strobe missing")
  // alpha path is independent of the color routing
  `ASSERT_HOLDS(a_alpha, clk, rst, done |-> (color.opacity_byte == to_byte(to_fix($past(pixel.opacity, 4)))), "alpha byte mismatch")
  // zero saturation must give gray whatever the sector
  `ASSERT_HOLDS(a_gray, clk, rst, (done && ($past(pixel.saturation, 4) == '0)) |-> ((color.red == color.green) && (color.green == color.blue)), "gray pixel not gray")

endmodule

// ===== rtl/hsvrgb_sector.sv =====
// First pipeline stage: hue sector, in-sector fraction, fixed-point inputs.
// Depends on hsvrgb_pkg.
module hsvrgb_sector (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  hsvrgb_pkg::pixel_t  pixel,
  output logic                out_valid,
  output hsvrgb_pkg::sect_t   sect
);
  import hsvrgb_pkg::*;

  h6_t     h6;
  h6_t     rem;
  sector_e sec;
  sect_t   sect_next;

  always_comb begin
    h6  = {1'b0, pixel.hue, 2'b00} + {2'b00, pixel.hue, 1'b0};
    sec = SEC_RY;
    // thresholds rise monotonically, last one passed wins; full turn clamps to magenta-red
    for (int k = 1; k < NUM_SECTORS; k++) begin
      if (h6 >= sector_base(sector_e'(3'(k)))) begin
        sec = sector_e'(3'(k));
      end
    end
    rem = h6 - sector_base(sec);
    sect_next.sector = sec;
    sect_next.frac   = to_fix(rem[CODE_W-1:0]);
    sect_next.sat    = to_fix(pixel.saturation);
    sect_next.val    = to_fix(pixel.brightness);
    sect_next.alpha  = to_fix(pixel.opacity);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    sect <= sect_next;
  end

endmodule

// ===== rtl/hsvrgb_mul.sv =====
// Two product stages: p, f*s, (1-f)*s, then q and t.
// Depends on hsvrgb_pkg.
module hsvrgb_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  hsvrgb_pkg::sect_t  sect,
  output logic               out_valid,
  output hsvrgb_pkg::mix_t   mix
);
  import hsvrgb_pkg::*;

  logic  prod_valid;
  prod_t prod;
  prod_t prod_next;
  mix_t  mix_next;

  always_comb begin
    prod_next.sector = sect.sector;
    prod_next.val    = sect.val;
    prod_next.alpha  = sect.alpha;
    prod_next.p      = fx_mul(sect.val, FX_ONE - sect.sat);
    prod_next.fs     = fx_mul(sect.frac, sect.sat);
    prod_next.gs     = fx_mul(FX_ONE - sect.frac, sect.sat);
  end

  always_comb begin
    mix_next.sector = prod.sector;
    mix_next.val    = prod.val;
    mix_next.alpha  = prod.alpha;
    mix_next.p      = prod.p;
    mix_next.q      = fx_mul(prod.val, FX_ONE - prod.fs);
    mix_next.t      = fx_mul(prod.val, FX_ONE - prod.gs);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      prod_valid <= in_valid;
      out_valid  <= prod_valid;
    end
    prod <= prod_next;
    mix  <= mix_next;
  end

endmodule

// ===== rtl/hsvrgb_pack.sv =====
// Last stage: routes v, p, q, t to the channels and scales to bytes.
// Depends on hsvrgb_pkg.
module hsvrgb_pack (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  hsvrgb_pkg::mix_t    mix,
  output logic                out_valid,
  output hsvrgb_pkg::color_t  color
);
  import hsvrgb_pkg::*;

  fx_t    r;
  fx_t    g;
  fx_t    b;
  color_t color_next;

  always_comb begin
    unique case (mix.sector)
      SEC_RY: begin
        r = mix.val; g = mix.t;   b = mix.p;
      end
      SEC_YG: begin
        r = mix.q;   g = mix.val; b = mix.p;
      end
      SEC_GC: begin
        r = mix.p;   g = mix.val; b = mix.t;
      end
      SEC_CB: begin
        r = mix.p;   g = mix.q;   b = mix.val;
      end
      SEC_BM: begin
        r = mix.t;   g = mix.p;   b = mix.val;
      end
      default: begin
        r = mix.val; g = mix.p;   b = mix.q;
      end
    endcase
    color_next.red          = to_byte(r);
    color_next.green        = to_byte(g);
    color_next.blue         = to_byte(b);
    color_next.opacity_byte = to_byte(mix.alpha);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    color <= color_next;
  end

endmodule
